### hw/rtl/miq_pkg.sv
// shared types and constants of the middle insertion queue
package miq_pkg;

  // default sizes
  localparam int unsigned Capacity = 1024;
  localparam int unsigned IdWidth  = 20;

  // command codes
  localparam logic [1:0] CmdTail   = 2'd0;
  localparam logic [1:0] CmdMiddle = 2'd1;
  localparam logic [1:0] CmdPop    = 2'd2;

  // status codes
  localparam logic [1:0] StServed = 2'd0;
  localparam logic [1:0] StEmpty  = 2'd1;
  localparam logic [1:0] StFull   = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_MOVE
  } state_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_SERVED,
    RES_EMPTY,
    RES_FULL
  } res_e;

endpackage

### hw/rtl/miq_ram.sv
// single-port-write, single-port-read memory with registered read data
module miq_ram #(
  parameter int unsigned Depth = 512,
  parameter int unsigned AddrW = 9,
  parameter int unsigned DataW = 20
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/middle_insert_queue.sv
// top level of the middle insertion queue: pointer control and two half stores
//
// usage
// - input channel (in_valid_i / in_ready_o) carries one command word:
//   command_i = tail push, middle push or pop, item_id_i = identifier
// - output channel (out_valid_o / out_ready_i) carries served_id_o and
//   status_o; a word comes out for every pop and for every dropped push,
//   successful pushes and the unused command code give no word
// - the queue is split into a front half and a back half, each a ring in its
//   own memory of CAPACITY/2 entries with registered read data
// - an item has an accept cycle and a move cycle: the accept cycle reads both
//   memories and writes the back memory, the move cycle writes the front memory
//   with the word shifted over from the back half and loads the output register
// - a new item is taken only after the last one's move cycle, as the front write
//   follows the back read; the output word appears in the cycle after the move
// - a stalled receiver holds the block in the move cycle only when an older
//   word still sits in the output register; otherwise the next item is taken
// - reset clears heads, counts and handshake state; memory contents are not
//   cleared, only data of written entries is ever used
module middle_insert_queue
  import miq_pkg::*;
#(
  parameter int unsigned CAPACITY = Capacity,
  parameter int unsigned ID_WIDTH = IdWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [ID_WIDTH-1:0] item_id_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ID_WIDTH-1:0] served_id_o,
  output logic [1:0]          status_o
);

  localparam int unsigned Half = CAPACITY / 2;
  localparam int unsigned AW   = (Half > 1) ? $clog2(Half) : 1;
  localparam int unsigned CW   = $clog2(Half + 1);
  localparam int unsigned SW   = CW + 1;

  localparam logic [AW-1:0] LastAddr = AW'(Half - 1);
  localparam logic [CW-1:0] HalfCnt  = CW'(Half);
  localparam logic [SW-1:0] HalfSum  = SW'(Half);
  localparam logic [SW-1:0] FullSum  = SW'(2 * Half);

  // ring helpers, addresses always below Half, counts up to Half
  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    ring_inc = (a == LastAddr) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
    ring_dec = (a == '0) ? LastAddr : a - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= HalfSum) begin
      s = s - HalfSum;
    end
    ring_add = s[AW-1:0];
  endfunction

  // control state
  state_e        state_q, state_d;
  res_e          res_q, res_d;
  logic [AW-1:0] front_head_q, front_head_d;
  logic [AW-1:0] back_head_q, back_head_d;
  logic [CW-1:0] front_cnt_q, front_cnt_d;
  logic [CW-1:0] back_cnt_q, back_cnt_d;
  logic          move_q, move_d;
  logic [AW-1:0] move_addr_q, move_addr_d;
  logic          fwd_q, fwd_d;
  logic          out_valid_q, out_valid_d;

  // payload registers
  logic [ID_WIDTH-1:0] fwd_data_q;
  logic [ID_WIDTH-1:0] served_q, served_d;
  logic [1:0]          status_q, status_d;

  // memory ports
  logic                front_we, front_re;
  logic [AW-1:0]       front_raddr;
  logic [ID_WIDTH-1:0] front_rdata;
  logic                back_we, back_re;
  logic [AW-1:0]       back_waddr, back_raddr;
  logic [ID_WIDTH-1:0] back_rdata;
  logic [ID_WIDTH-1:0] move_data;

  // post-command pointer values, before the rebalance move
  logic [AW-1:0] fh1, bh1;
  logic [CW-1:0] fc1, bc1;
  logic          accept, full, finish;

  assign accept = in_valid_i && in_ready_o;
  assign full   = ((SW'(front_cnt_q) + SW'(back_cnt_q)) >= FullSum) ||
                  (back_cnt_q >= HalfCnt);

  // command decode and pointer update at accept
  always_comb begin
    fh1         = front_head_q;
    bh1         = back_head_q;
    fc1         = front_cnt_q;
    bc1         = back_cnt_q;
    back_we     = 1'b0;
    back_waddr  = ring_add(back_head_q, back_cnt_q);
    res_d       = RES_NONE;
    unique case (command_i)
      CmdTail: begin
        if (full) begin
          res_d = RES_FULL;
        end else begin
          back_we = 1'b1;
          bc1     = back_cnt_q + CW'(1);
        end
      end
      CmdMiddle: begin
        if (full) begin
          res_d = RES_FULL;
        end else begin
          bh1        = ring_dec(back_head_q);
          back_we    = 1'b1;
          back_waddr = bh1;
          bc1        = back_cnt_q + CW'(1);
        end
      end
      CmdPop: begin
        if (front_cnt_q == '0) begin
          res_d = RES_EMPTY;
        end else begin
          res_d = RES_SERVED;
          fh1   = ring_inc(front_head_q);
          fc1   = front_cnt_q - CW'(1);
        end
      end
      default: begin
        res_d = RES_NONE;
      end
    endcase

    // rebalance: head of back half moves to tail of front half
    move_d       = (fc1 < bc1) && (fc1 < HalfCnt);
    move_addr_d  = ring_add(fh1, fc1);
    front_head_d = fh1;
    front_cnt_d  = move_d ? fc1 + CW'(1) : fc1;
    back_cnt_d   = move_d ? bc1 - CW'(1) : bc1;
    back_head_d  = move_d ? ring_inc(bh1) : bh1;
    back_raddr   = bh1;
    // same-entry write and read in one cycle: bypass the memory
    fwd_d        = back_we && (back_waddr == bh1);
  end

  assign back_re     = accept;
  assign front_re    = accept;
  assign front_raddr = front_head_q;
  assign front_we    = (state_q == ST_MOVE) && move_q;
  assign move_data   = fwd_q ? fwd_data_q : back_rdata;

  // the move cycle may end unless an older word blocks the output register
  assign finish = (res_q == RES_NONE) || !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    served_d    = served_q;
    status_d    = status_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (finish) begin
          state_d = ST_IDLE;
          if (res_q != RES_NONE) begin
            out_valid_d = 1'b1;
            served_d    = (res_q == RES_SERVED) ? front_rdata : '0;
            unique case (res_q)
              RES_SERVED: status_d = StServed;
              RES_EMPTY:  status_d = StEmpty;
              default:    status_d = StFull;
            endcase
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      res_q        <= RES_NONE;
      front_head_q <= '0;
      back_head_q  <= '0;
      front_cnt_q  <= '0;
      back_cnt_q   <= '0;
      move_q       <= 1'b0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        res_q        <= res_d;
        front_head_q <= front_head_d;
        back_head_q  <= back_head_d;
        front_cnt_q  <= front_cnt_d;
        back_cnt_q   <= back_cnt_d;
        move_q       <= move_d;
        fwd_q        <= fwd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      move_addr_q <= move_addr_d;
      fwd_data_q  <= item_id_i;
    end
    served_q <= served_d;
    status_q <= status_d;
  end

  miq_ram #(
    .Depth (Half),
    .AddrW (AW),
    .DataW (ID_WIDTH)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (front_we),
    .waddr_i (move_addr_q),
    .wdata_i (move_data),
    .re_i    (front_re),
    .raddr_i (front_raddr),
    .rdata_o (front_rdata)
  );

  miq_ram #(
    .Depth (Half),
    .AddrW (AW),
    .DataW (ID_WIDTH)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (back_we && accept),
    .waddr_i (back_waddr),
    .wdata_i (item_id_i),
    .re_i    (back_re),
    .raddr_i (back_raddr),
    .rdata_o (back_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign served_id_o = served_q;
  assign status_o    = status_q;

`ifndef NO_ASSERTIONS
  // front half holds as many words as the back half or one more
  a_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_cnt_q == back_cnt_q) || (front_cnt_q == back_cnt_q + CW'(1)))
    else $error("halves out of balance");

  // total occupancy never exceeds the two halves
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(front_cnt_q) + SW'(back_cnt_q)) <= FullSum)
    else $error("occupancy beyond capacity");

  // ring heads stay inside their store
  a_heads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(front_head_q) < HalfSum) && (SW'(back_head_q) < HalfSum))
    else $error("ring head out of range");

  // every accepted word is followed by its move cycle
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_MOVE))
    else $error("accepted word without move cycle");
`endif

endmodule

### bench/miq_checker.sv
// checker for the middle insertion queue: predicts each reply word and compares it
module miq_checker
  import miq_pkg::*;
#(
  parameter int unsigned CAPACITY = Capacity,
  parameter int unsigned ID_WIDTH = IdWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          command_i,
  input  logic [ID_WIDTH-1:0] item_id_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [ID_WIDTH-1:0] served_id_i,
  input  logic [1:0]          status_i,
  output int                  fail_count_o,
  output int                  pending_count_o
);

  localparam int HalfDepth = CAPACITY / 2;

  typedef struct packed {
    logic [ID_WIDTH-1:0] served_id;
    logic [1:0]          status;
  } reply_t;

  // queue contents split the same way as the block keeps them
  logic [ID_WIDTH-1:0] front_half[$];
  logic [ID_WIDTH-1:0] back_half[$];
  reply_t              replies_due[$];
  reply_t              want;
  int                  fails = 0;

  task automatic note_failure(input string what);
    fails++;
    if (fails <= 10) $display("mismatch: %s", what);
  endtask

  function automatic void apply_command(input logic [1:0] cmd,
                                        input logic [ID_WIDTH-1:0] id);
    reply_t r;
    if (cmd == CmdTail || cmd == CmdMiddle) begin
      if (front_half.size() + back_half.size() >= 2 * HalfDepth ||
          back_half.size() >= HalfDepth) begin
        r.served_id = '0;
        r.status    = StFull;
        replies_due.push_back(r);
      end else if (cmd == CmdTail) begin
        back_half.push_back(id);
      end else begin
        back_half.push_front(id);
      end
    end else if (cmd == CmdPop) begin
      if (front_half.size() == 0) begin
        r.served_id = '0;
        r.status    = StEmpty;
      end else begin
        r.served_id = front_half.pop_front();
        r.status    = StServed;
      end
      replies_due.push_back(r);
    end
    // keep the front half as long as the back half or one longer
    if (front_half.size() < back_half.size() && front_half.size() < HalfDepth)
      front_half.push_back(back_half.pop_front());
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      // an output word can never belong to an input accepted at the same edge
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          note_failure($sformatf("unexpected word served_id %h status %0d",
                                 served_id_i, status_i));
        end else begin
          want = replies_due.pop_front();
          if (served_id_i !== want.served_id || status_i !== want.status)
            note_failure($sformatf("served_id exp %h got %h, status exp %0d got %0d",
                                   want.served_id, served_id_i, want.status, status_i));
        end
      end
      if (in_valid_i && in_ready_i) apply_command(command_i, item_id_i);
    end
    fail_count_o    <= fails;
    pending_count_o <= replies_due.size();
  end

endmodule

### bench/tb.sv
// testbench top for the middle insertion queue: stimulus, stalls and verdict
module tb;
  import miq_pkg::*;

  // the one command code the block ignores
  localparam logic [1:0] CmdUnused = 2'd3;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [1:0]         command_i   = CmdTail;
  logic [IdWidth-1:0] item_id_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [IdWidth-1:0] served_id_o;
  logic [1:0]         status_o;

  int fail_count;
  int pending_count;

  // no new gaps start on either side while set
  bit quiet = 1'b0;
  int stall_left = 0;

  always #1 clk_i = ~clk_i;

  middle_insert_queue #(
    .CAPACITY(Capacity),
    .ID_WIDTH(IdWidth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .item_id_i  (item_id_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .served_id_o(served_id_o),
    .status_o   (status_o)
  );

  miq_checker #(
    .CAPACITY(Capacity),
    .ID_WIDTH(IdWidth)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .command_i      (command_i),
    .item_id_i      (item_id_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .served_id_i    (served_id_o),
    .status_i       (status_o),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IdWidth-1:0] rand_id();
    return IdWidth'($urandom_range(0, (1 << IdWidth) - 1));
  endfunction

  // push share splits evenly between tail and middle, then pops, the rest is the unused code
  function automatic logic [1:0] pick_command(input int push_pct, input int pop_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) return ($urandom_range(0, 1) == 0) ? CmdTail : CmdMiddle;
    if (roll < push_pct + pop_pct) return CmdPop;
    return CmdUnused;
  endfunction

  // receiver side: random stall stretches on out_ready_i
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet && $urandom_range(0, 2) == 0) stall_left <= pick_gap();
    end
  end

  // sender side: valid stays high on return, so a back-to-back word
  // replaces the payload in the same step instead of dropping valid
  task automatic send_word(input logic [1:0] cmd, input logic [IdWidth-1:0] id);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    item_id_i  <= id;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold the sender until every predicted word has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  initial begin
    int net;
    int n;
    logic [1:0] cmd;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pop, ignored code, id extremes, both push kinds
    // on even and odd length, drain past empty, middle push into empty queue
    send_word(CmdPop, '0);
    send_word(CmdUnused, '1);
    send_word(CmdTail, '0);
    send_word(CmdTail, '1);
    send_word(CmdMiddle, 20'h12345);
    send_word(CmdMiddle, 20'haaaaa);
    send_word(CmdTail, 20'h55555);
    send_word(CmdUnused, '1);
    send_word(CmdMiddle, 20'h80001);
    repeat (7) send_word(CmdPop, '1);
    send_word(CmdMiddle, 20'h00001);
    send_word(CmdUnused, '0);
    send_word(CmdPop, '0);
    send_word(CmdPop, '0);
    wait_drained();

    // mixed traffic around small lengths
    for (n = 0; n < 200; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_word(pick_command(65, 30), rand_id());
    end
    wait_drained();

    // fill past capacity so dropped pushes show up
    net = 0;
    n   = 0;
    while (net < 1040) begin
      if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      cmd = pick_command(93, 4);
      send_word(cmd, rand_id());
      if (cmd == CmdPop) net--;
      else if (cmd != CmdUnused) net++;
      n++;
    end

    // drain part of the queue back down
    for (n = 0; n < 150; n++) begin
      if (n % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_word(pick_command(10, 87), rand_id());
    end

    quiet = 1'b0;
    wait_drained();
    // room for any stray word still in the pipeline
    repeat (16) @(posedge clk_i);

    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/miq_pkg.sv
hw/rtl/miq_ram.sv
hw/rtl/middle_insert_queue.sv
bench/miq_checker.sv
bench/tb.sv
